// ===== design/slmt_pkg.sv =====
// ----------------------------------------------------------------------------
// slmt_pkg: shared types, constants and tables of the swept level tone mixer
// widths of the sample, level and state words, register indexes, the
// decibel-to-linear amplitude table and the quarter-wave sine generator
// ----------------------------------------------------------------------------
package slmt_pkg;

    // field and state widths
    localparam int MIC_W      = 16;
    localparam int LEVEL_W    = 15;
    localparam int PHASE_W    = 32;
    localparam int STEP_W     = 31;
    localparam int POS_W      = 19;
    localparam int NUM_W      = 20;
    localparam int NUMER_W    = 34;
    localparam int Q_W        = 14;
    localparam int DIV_SHIFT  = 21;
    localparam int AMP_W      = 25;
    localparam int FRAC_W     = 8;
    localparam int K_W        = 6;
    localparam int SIN_W      = 15;
    localparam int MAG_W      = SIN_W + AMP_W;
    localparam int TONE_W     = 16;
    localparam int SUM_W      = 18;

    // pipeline depth, accept stage to output register
    localparam int STAGES     = 9;

    // level span in 1/256 dB (50 dB)
    localparam int LEVEL_SPAN = 12800;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 8'd1;
    localparam logic [STEP_W-1:0]    PHASE_STEP_RESET = 31'd39370534;

    // state word held in the state memory
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [POS_W-1:0]   pos;
    } t_tone_state;

    // state memory access strobes
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctrl;

    // decibel table: one decade in 1 dB steps, Q0.24
    localparam int DB_STEPS      = 20;
    localparam int AMP_TAB_DEPTH = 52;
    localparam int unsigned DB_BASE_Q24 [DB_STEPS] = '{
        16777216, 14952710, 13326616, 11877359, 10585708,
        9434522,  8408526,  7494107,  6679130,  5952781,
        5305422,  4728462,  4214246,  3755951,  3347495,
        2983458,  2659010,  2369845,  2112126,  1882435
    };

    typedef logic [AMP_W-1:0] t_amp_tab [AMP_TAB_DEPTH];

    // amplitude per whole dB of attenuation, decades rounded half up
    function automatic t_amp_tab build_amp_tab();
        t_amp_tab    tab;
        int unsigned a;
        for (int k = 0; k < AMP_TAB_DEPTH; k++) begin
            a = DB_BASE_Q24[k % DB_STEPS];
            if (k / DB_STEPS == 1) begin
                a = (a + 5) / 10;
            end else if (k / DB_STEPS >= 2) begin
                a = (a + 50) / 100;
            end
            tab[k] = AMP_W'(a);
        end
        return tab;
    endfunction

    localparam t_amp_tab AMP_TAB = build_amp_tab();

    // quarter-wave sine in Q30 from an odd polynomial, scaled to Q1.15 magnitude
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    function automatic logic [SIN_W-1:0] sine_mag_q15(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] s;
        u2 = (u * u) >> 30;
        t  = 64'd172274;
        t  = 64'd5026993    - ((u2 * t) >> 30);
        t  = 64'd85569306   - ((u2 * t) >> 30);
        t  = 64'd693598669  - ((u2 * t) >> 30);
        t  = 64'd1686629713 - ((u2 * t) >> 30);
        t  = (u * t) >> 30;
        if (t > Q30_ONE) begin
            t = Q30_ONE;
        end
        s = (t * 64'd32767 + (64'd1 << 29)) >> 30;
        return s[SIN_W-1:0];
    endfunction

endpackage

// ===== design/slmt_in_if.sv =====
// ----------------------------------------------------------------------------
// slmt_in_if: microphone sample channel
// one beat carries one signed Q1.15 sample
// ----------------------------------------------------------------------------
interface slmt_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [slmt_pkg::MIC_W-1:0]  mic_sample;

    modport source (output valid, output mic_sample, input ready);
    modport sink   (input valid, input mic_sample, output ready);
endinterface

// ===== design/slmt_out_if.sv =====
// ----------------------------------------------------------------------------
// slmt_out_if: mixed sample channel
// one beat carries the mixed sample and the current tone level
// ----------------------------------------------------------------------------
interface slmt_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [slmt_pkg::MIC_W-1:0]    mixed_sample;
    logic signed [slmt_pkg::LEVEL_W-1:0]  level_db;

    modport source (output valid, output mixed_sample, output level_db, input ready);
    modport sink   (input valid, input mixed_sample, input level_db, output ready);
endinterface

// ===== design/slmt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// slmt_cfg_if: register write channel
// one beat writes one register, selected by index
// ----------------------------------------------------------------------------
interface slmt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [slmt_pkg::CFG_IDX_W-1:0]    index;
    logic [slmt_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/slmt_state_store.sv =====
// ----------------------------------------------------------------------------
// slmt_state_store: phase and sweep state memory with read-modify-write
// read when a sample is accepted, written back advanced when it moves on;
// the write data is forwarded to a read in the same cycle
// ----------------------------------------------------------------------------
module slmt_state_store #(
    parameter int PERIOD = 384000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slmt_pkg::t_mem_ctrl           i_ctrl,
    input  logic [slmt_pkg::STEP_W-1:0]   i_phase_step,
    output slmt_pkg::t_tone_state         o_state
);

    slmt_pkg::t_tone_state r_mem [1];
    logic                  r_mem_ok;
    slmt_pkg::t_tone_state r_rd;
    slmt_pkg::t_tone_state n_wr;
    logic [slmt_pkg::POS_W:0] pos_inc;

    // advance phase and sweep position, position wraps at the period
    always_comb begin
        pos_inc     = {1'b0, r_rd.pos} + (slmt_pkg::POS_W + 1)'(1);
        n_wr.phase  = r_rd.phase + {1'b0, i_phase_step};
        if (32'(pos_inc) >= 32'(PERIOD)) begin
            n_wr.pos = '0;
        end else begin
            n_wr.pos = pos_inc[slmt_pkg::POS_W-1:0];
        end
    end

    // entry reads as zero until first written after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_ok <= 1'b0;
        end else if (i_ctrl.wr) begin
            r_mem_ok <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_mem[0] <= n_wr;
        end
    end

    // registered read port with forwarding from the write port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd) begin
            if (i_ctrl.wr) begin
                r_rd <= n_wr;
            end else if (r_mem_ok) begin
                r_rd <= r_mem[0];
            end else begin
                r_rd <= '0;
            end
        end
    end

    assign o_state = r_rd;

endmodule

// ===== design/slmt_sine_rom.sv =====
// ----------------------------------------------------------------------------
// slmt_sine_rom: quarter-wave sine magnitude rom
// one entry per quarter-cycle step plus the peak, registered read
// ----------------------------------------------------------------------------
module slmt_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [TABLE_BITS-2:0]        i_addr,
    output logic [slmt_pkg::SIN_W-1:0]   o_mag
);

    localparam int DEPTH   = (1 << (TABLE_BITS - 2)) + 1;
    localparam int U_SHIFT = 30 - (TABLE_BITS - 2);

    typedef logic [slmt_pkg::SIN_W-1:0] t_rom [DEPTH];

    // fill from the polynomial at elaboration
    function automatic t_rom build_rom();
        t_rom rom;
        for (int m = 0; m < DEPTH; m++) begin
            rom[m] = slmt_pkg::sine_mag_q15(64'(m) << U_SHIFT);
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [slmt_pkg::SIN_W-1:0] r_mag;

    // registered read, held while the stage stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= ROM[i_addr];
        end
    end

    assign o_mag = r_mag;

endmodule

// ===== design/swept_level_tone_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// swept_level_tone_mixer_unit: microphone mixer with a swept-level sine tone
// adds a sine of a 32-bit phase accumulator, scaled by a level that sweeps as
// a triangle between -50 dB and 0 dB, to each sample with saturation when tone_enable is set
//
//   channel   role    beat
//   i_mic     sink    mic_sample
//   o_mix     source  mixed_sample, level_db
//   i_cfg     sink    index, data (0 tone_enable, 1 phase_step)
//
// one sample per cycle while o_mix takes results; a result passes from acceptance
// through nine stages (state read, divide estimate, divide correction, table,
// two interpolation steps, tone multiply, mix and saturate)
// the state memory is read as a sample is accepted and written as it leaves the
// first stage; a sample accepted in that cycle takes the new state by forwarding
// synchronous reset clears the stage valid bits and the state entry flag
// a stage holds only while the stage after it is full and held, so empty
// stages keep filling while o_mix is stalled; register writes always ready
// ----------------------------------------------------------------------------
module swept_level_tone_mixer_unit #(
    parameter int SAMPLE_RATE     = 48000,
    parameter int SWEEP_SECONDS   = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slmt_in_if.sink     i_mic,
    slmt_out_if.source  o_mix,
    slmt_cfg_if.sink    i_cfg
);

    localparam int MIC_W   = slmt_pkg::MIC_W;
    localparam int LEVEL_W = slmt_pkg::LEVEL_W;
    localparam int NUM_W   = slmt_pkg::NUM_W;
    localparam int NUMER_W = slmt_pkg::NUMER_W;
    localparam int Q_W     = slmt_pkg::Q_W;
    localparam int AMP_W   = slmt_pkg::AMP_W;
    localparam int FRAC_W  = slmt_pkg::FRAC_W;
    localparam int K_W     = slmt_pkg::K_W;
    localparam int SIN_W   = slmt_pkg::SIN_W;
    localparam int MAG_W   = slmt_pkg::MAG_W;
    localparam int TONE_W  = slmt_pkg::TONE_W;
    localparam int SUM_W   = slmt_pkg::SUM_W;
    localparam int STAGES  = slmt_pkg::STAGES;

    // sweep period and its scaled reciprocal
    localparam longint PERIOD  = longint'(SAMPLE_RATE) * longint'(SWEEP_SECONDS);
    localparam longint RECIP   = (longint'(slmt_pkg::LEVEL_SPAN) << slmt_pkg::DIV_SHIFT)
                                 / PERIOD;
    localparam int     P_W     = $clog2(PERIOD + 1);
    localparam int     M_W     = $clog2(RECIP + 1);
    localparam int     PRODR_W = slmt_pkg::DIV_SHIFT + Q_W;
    localparam int     ROM_AW  = SINE_TABLE_BITS - 1;

    localparam logic [P_W-1:0]     P_C    = P_W'(PERIOD);
    localparam logic [M_W-1:0]     M_C    = M_W'(RECIP);
    localparam logic [NUMER_W-1:0] P_N    = NUMER_W'(PERIOD);
    localparam logic [NUMER_W-1:0] P2_N   = NUMER_W'(2 * PERIOD);
    localparam logic [NUMER_W-1:0] HALF_N = NUMER_W'(PERIOD / 2);
    localparam logic [ROM_AW-1:0]  QN     = ROM_AW'(1) << (SINE_TABLE_BITS - 2);

    // configuration registers
    logic                          r_tone_en;
    logic [slmt_pkg::STEP_W-1:0]   r_phase_step;

    // stage handshake
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] adv;
    logic              in_ready;
    logic              acc;

    // state memory and rom
    slmt_pkg::t_mem_ctrl   mem_ctrl;
    slmt_pkg::t_tone_state state;
    logic [SIN_W-1:0]      rom_mag;

    // stage 0 logic
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [ROM_AW-1:0]          rom_addr;
    logic [NUMER_W-1:0]         two_pos;
    logic [NUMER_W-1:0]         num_w;
    logic [NUM_W+M_W-1:0]       prod_full;

    // stage payloads
    logic signed [MIC_W-1:0]   r_mic   [0:STAGES-2];
    logic                      r_neg   [1:STAGES-2];
    logic [SIN_W-1:0]          r_sin   [2:STAGES-3];
    logic [LEVEL_W-1:0]        r_level [4:STAGES-2];
    logic [NUM_W-1:0]          r_num;
    logic [PRODR_W-1:0]        r_prod;
    logic [Q_W-1:0]            r_qest;
    logic [NUMER_W-1:0]        r_numer;
    logic [NUMER_W-1:0]        r_qp;
    logic [Q_W-1:0]            r_q;
    logic [AMP_W-1:0]          r_ak4;
    logic [AMP_W-1:0]          r_diff;
    logic [FRAC_W-1:0]         r_f;
    logic [AMP_W-1:0]          r_ak5;
    logic [AMP_W+FRAC_W-1:0]   r_dprod;
    logic [AMP_W-1:0]          r_amp;
    logic [MAG_W-1:0]          r_mag;
    logic signed [MIC_W-1:0]   r_out_mixed;
    logic [LEVEL_W-1:0]        r_out_level;

    // later stage logic
    logic [Q_W-1:0]            qest;
    logic [Q_W+P_W-1:0]        qp_full;
    logic [NUMER_W-1:0]        numer;
    logic [NUMER_W-1:0]        rem;
    logic [Q_W-1:0]            q_fix;
    logic [Q_W-1:0]            att;
    logic [K_W-1:0]            k;
    logic [K_W-1:0]            k_next;
    logic [AMP_W-1:0]          amp_k;
    logic [AMP_W-1:0]          amp_n;
    logic [LEVEL_W-1:0]        level;
    logic [MAG_W:0]            mag_rnd;
    logic [TONE_W-1:0]         tone;
    logic signed [SUM_W-1:0]   tone_s;
    logic signed [SUM_W-1:0]   sum;
    logic signed [MIC_W-1:0]   mixed;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_en    <= 1'b0;
            r_phase_step <= slmt_pkg::PHASE_STEP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                slmt_pkg::CFG_TONE_ENABLE: r_tone_en    <= i_cfg.data[0];
                slmt_pkg::CFG_PHASE_STEP:  r_phase_step <= i_cfg.data[slmt_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // stage advance chain, from the output back to the input
    always_comb begin
        adv[STAGES-1] = r_vld[STAGES-1] & o_mix.ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = r_vld[i] & (~r_vld[i+1] | adv[i+1]);
        end
        in_ready = i_rst_n & (~r_vld[0] | adv[0]);
        acc      = i_mic.valid & in_ready;
        n_vld[0] = acc | (r_vld[0] & ~adv[0]);
        for (int i = 1; i < STAGES; i++) begin
            n_vld[i] = adv[i-1] | (r_vld[i] & ~adv[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_mic.ready = in_ready;

    // state read on accept, write back as stage 0 moves on
    assign mem_ctrl.rd = acc;
    assign mem_ctrl.wr = adv[0];

    slmt_state_store #(
        .PERIOD (int'(PERIOD))
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (mem_ctrl),
        .i_phase_step (r_phase_step),
        .o_state      (state)
    );

    // stage 0: triangle numerator, rom address from the phase top bits
    always_comb begin
        idx     = state.phase[slmt_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
        if (idx[SINE_TABLE_BITS-2]) begin
            rom_addr = QN - ROM_AW'(idx[SINE_TABLE_BITS-3:0]);
        end else begin
            rom_addr = ROM_AW'(idx[SINE_TABLE_BITS-3:0]);
        end
        two_pos = NUMER_W'({state.pos, 1'b0});
        if (two_pos < P_N) begin
            num_w = two_pos;
        end else begin
            num_w = P2_N - two_pos;
        end
        prod_full = num_w[NUM_W-1:0] * M_C;
    end

    slmt_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (adv[0]),
        .i_addr (rom_addr),
        .o_mag  (rom_mag)
    );

    // stage 1: quotient estimate times period, scaled numerator
    always_comb begin
        qest    = r_prod[PRODR_W-1:slmt_pkg::DIV_SHIFT];
        qp_full = qest * P_C;
        numer   = NUMER_W'(r_num) * NUMER_W'(slmt_pkg::LEVEL_SPAN) + HALF_N;
    end

    // stage 2: correct the estimate by up to two
    always_comb begin
        rem = r_numer - r_qp;
        if (rem >= P2_N) begin
            q_fix = r_qest + Q_W'(2);
        end else if (rem >= P_N) begin
            q_fix = r_qest + Q_W'(1);
        end else begin
            q_fix = r_qest;
        end
    end

    // stage 3: attenuation split into whole dB and fraction, table lookups
    always_comb begin
        att    = Q_W'(slmt_pkg::LEVEL_SPAN) - r_q;
        k      = att[Q_W-1:FRAC_W];
        k_next = k + K_W'(1);
        amp_k  = slmt_pkg::AMP_TAB[k];
        amp_n  = slmt_pkg::AMP_TAB[k_next];
        level  = LEVEL_W'({1'b0, r_q}) - LEVEL_W'(slmt_pkg::LEVEL_SPAN);
    end

    // stage 7: round the tone, mix and saturate
    always_comb begin
        mag_rnd = {1'b0, r_mag} + ((MAG_W + 1)'(1) << 24);
        tone    = mag_rnd[MAG_W:25];
        tone_s  = $signed({{(SUM_W - TONE_W){1'b0}}, tone});
        sum     = SUM_W'(r_mic[STAGES-2]);
        if (r_tone_en) begin
            if (r_neg[STAGES-2]) begin
                sum = sum - tone_s;
            end else begin
                sum = sum + tone_s;
            end
        end
        if (sum > SUM_W'(32767)) begin
            mixed = 16'sh7fff;
        end else if (sum < -SUM_W'(32768)) begin
            mixed = 16'sh8000;
        end else begin
            mixed = sum[MIC_W-1:0];
        end
    end

    // stage registers, each loaded as the stage before it moves on
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mic[0] <= i_mic.mic_sample;
        end
        for (int i = 1; i <= STAGES - 2; i++) begin
            if (adv[i-1]) begin
                r_mic[i] <= r_mic[i-1];
            end
        end
        if (adv[0]) begin
            r_neg[1] <= idx[SINE_TABLE_BITS-1];
            r_num    <= num_w[NUM_W-1:0];
            r_prod   <= PRODR_W'(prod_full);
        end
        for (int i = 2; i <= STAGES - 2; i++) begin
            if (adv[i-1]) begin
                r_neg[i] <= r_neg[i-1];
            end
        end
        if (adv[1]) begin
            r_sin[2] <= rom_mag;
            r_qest   <= qest;
            r_numer  <= numer;
            r_qp     <= NUMER_W'(qp_full);
        end
        for (int i = 3; i <= STAGES - 3; i++) begin
            if (adv[i-1]) begin
                r_sin[i] <= r_sin[i-1];
            end
        end
        if (adv[2]) begin
            r_q <= q_fix;
        end
        if (adv[3]) begin
            r_level[4] <= level;
            r_ak4      <= amp_k;
            r_diff     <= amp_k - amp_n;
            r_f        <= att[FRAC_W-1:0];
        end
        for (int i = 5; i <= STAGES - 2; i++) begin
            if (adv[i-1]) begin
                r_level[i] <= r_level[i-1];
            end
        end
        if (adv[4]) begin
            r_ak5   <= r_ak4;
            r_dprod <= r_diff * r_f;
        end
        if (adv[5]) begin
            r_amp <= r_ak5 - r_dprod[AMP_W+FRAC_W-1:FRAC_W];
        end
        if (adv[6]) begin
            r_mag <= r_sin[STAGES-3] * r_amp;
        end
        if (adv[7]) begin
            r_out_mixed <= mixed;
            r_out_level <= r_level[STAGES-2];
        end
    end

    // output beat
    assign o_mix.valid        = r_vld[STAGES-1];
    assign o_mix.mixed_sample = r_out_mixed;
    assign o_mix.level_db     = $signed(r_out_level);

endmodule

// ===== dv/slmt_mix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slmt_mix_checker: result checker for the swept level tone mixer
// watches the register, sample and result channels, keeps its own copy of the
// registers, phase and sweep position, works out the mixed sample and level
// for every accepted sample and compares each result beat with the oldest one
// ----------------------------------------------------------------------------
module slmt_mix_checker #(
    parameter int SAMPLE_RATE     = 48000,
    parameter int SWEEP_SECONDS   = 8,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    slmt_in_if    i_mic,
    slmt_out_if   i_mix,
    slmt_cfg_if   i_cfg,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int MIC_W   = slmt_pkg::MIC_W;
    localparam int LEVEL_W = slmt_pkg::LEVEL_W;
    localparam int STEP_W  = slmt_pkg::STEP_W;
    localparam int PHASE_W = slmt_pkg::PHASE_W;
    localparam int POS_W   = slmt_pkg::POS_W;
    localparam int FRAC_W  = slmt_pkg::FRAC_W;

    localparam longint unsigned SWEEP_LEN = 64'(SAMPLE_RATE) * 64'(SWEEP_SECONDS);
    localparam int unsigned     DEEPEST_DB = 50;
    localparam int              MIX_MAX    = (1 << (MIC_W - 1)) - 1;
    localparam int              MIX_MIN    = -(1 << (MIC_W - 1));

    typedef struct packed {
        logic signed [MIC_W-1:0]   mixed;
        logic signed [LEVEL_W-1:0] level;
    } t_mix_result;

    // shadow registers and tone state
    logic                tone_on;
    logic [STEP_W-1:0]   step;
    logic [PHASE_W-1:0]  phase;
    logic [POS_W-1:0]    pos;
    t_mix_result         mix_due [$];
    int                  errors = 0;

    // triangle level in 1/256 dB for a sweep position
    function automatic logic signed [LEVEL_W-1:0] sweep_level(input logic [POS_W-1:0] p);
        longint unsigned twice;
        longint unsigned num;
        int              rise;
        twice = 64'(p) << 1;
        num   = (twice < SWEEP_LEN) ? twice : 2 * SWEEP_LEN - twice;
        rise  = int'((64'(slmt_pkg::LEVEL_SPAN) * num + SWEEP_LEN / 2) / SWEEP_LEN);
        return LEVEL_W'(rise - slmt_pkg::LEVEL_SPAN);
    endfunction

    // linear gain in Q0.24 for a whole number of dB of attenuation
    function automatic longint unsigned whole_db_gain(input int unsigned k);
        longint unsigned g;
        g = slmt_pkg::DB_BASE_Q24[k % slmt_pkg::DB_STEPS];
        if (k / slmt_pkg::DB_STEPS == 1) begin
            g = (g + 5) / 10;
        end else if (k / slmt_pkg::DB_STEPS >= 2) begin
            g = (g + 50) / 100;
        end
        return g;
    endfunction

    // gain for a level, interpolated between whole dB steps
    function automatic longint unsigned level_gain(input logic signed [LEVEL_W-1:0] lvl);
        int unsigned     att;
        int unsigned     k;
        int unsigned     f;
        longint unsigned g;
        longint unsigned g_next;
        att = -int'(lvl);
        k   = att >> FRAC_W;
        f   = att & ((1 << FRAC_W) - 1);
        g   = whole_db_gain(k);
        if (k < DEEPEST_DB) begin
            g_next = whole_db_gain(k + 1);
            g      = g - (((g - g_next) * f) >> FRAC_W);
        end
        return g;
    endfunction

    // signed Q1.15 sine from the top phase bits, odd polynomial per quarter
    function automatic int tone_sine(input logic [PHASE_W-1:0] ph);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [1:0]                 quad;
        longint unsigned            u;
        longint unsigned            u2;
        longint unsigned            t;
        longint unsigned            s;
        idx  = ph[PHASE_W-1 -: SINE_TABLE_BITS];
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        u    = 64'(idx[SINE_TABLE_BITS-3:0]) << (32 - SINE_TABLE_BITS);
        if (quad[0]) begin
            u = (64'd1 << 30) - u;
        end
        u2 = (u * u) >> 30;
        t  = 64'd172274;
        t  = 64'd5026993 - ((u2 * t) >> 30);
        t  = 64'd85569306 - ((u2 * t) >> 30);
        t  = 64'd693598669 - ((u2 * t) >> 30);
        t  = 64'd1686629713 - ((u2 * t) >> 30);
        t  = (u * t) >> 30;
        if (t > (64'd1 << 30)) begin
            t = 64'd1 << 30;
        end
        s = (t * 64'd32767 + (64'd1 << 29)) >> 30;
        return quad[1] ? -int'(s) : int'(s);
    endfunction

    // mixed sample and level for one microphone sample at the current state
    function automatic t_mix_result mixed_beat_for(input logic signed [MIC_W-1:0] mic_in);
        t_mix_result     r;
        longint unsigned gain;
        longint unsigned mag;
        int              sn;
        int              sn_mag;
        int              tone;
        int              sum;
        r.level = sweep_level(pos);
        gain    = level_gain(r.level);
        sum     = int'(mic_in);
        if (tone_on) begin
            sn     = tone_sine(phase);
            sn_mag = (sn < 0) ? -sn : sn;
            mag    = 64'(sn_mag) * gain;
            tone   = int'((mag + (64'd1 << 24)) >> 25);
            sum    = sum + ((sn < 0) ? -tone : tone);
        end
        if (sum > MIX_MAX) begin
            sum = MIX_MAX;
        end
        if (sum < MIX_MIN) begin
            sum = MIX_MIN;
        end
        r.mixed = MIC_W'(sum);
        return r;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // one pass per clock: register writes, result beats, then sample beats
    always @(posedge i_clk) begin : watch
        t_mix_result due_r;
        if (!i_rst_n) begin
            tone_on = 1'b0;
            step    = slmt_pkg::PHASE_STEP_RESET;
            phase   = '0;
            pos     = '0;
            mix_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    slmt_pkg::CFG_TONE_ENABLE: tone_on = i_cfg.data[0];
                    slmt_pkg::CFG_PHASE_STEP:  step    = i_cfg.data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_mix.valid && i_mix.ready) begin
                if (mix_due.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none expected, mixed %0d level %0d",
                             $time, i_mix.mixed_sample, i_mix.level_db);
                end else begin
                    due_r = mix_due.pop_front();
                    if (i_mix.mixed_sample !== due_r.mixed) begin
                        report_field("mixed_sample", due_r.mixed, i_mix.mixed_sample);
                    end
                    if (i_mix.level_db !== due_r.level) begin
                        report_field("level_db", due_r.level, i_mix.level_db);
                    end
                end
            end
            if (i_mic.valid && i_mic.ready) begin
                mix_due.push_back(mixed_beat_for(i_mic.mic_sample));
                phase = phase + PHASE_W'(step);
                pos   = (64'(pos) + 1 >= SWEEP_LEN) ? '0 : pos + 1'b1;
            end
        end
        o_pending    <= mix_due.size();
        o_fail_count <= errors;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the swept level tone mixer
// drives edge-case and random microphone samples under several register
// settings with random idling on both channels, then streams with no idling;
// the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module testbench;

    localparam int STAGES     = slmt_pkg::STAGES;
    localparam int MIC_W      = slmt_pkg::MIC_W;
    localparam int CFG_IDX_W  = slmt_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = slmt_pkg::CFG_DATA_W;

    localparam int SAMPLE_RATE     = 48000;
    localparam int SWEEP_SECONDS   = 8;
    localparam int SINE_TABLE_BITS = 10;

    localparam int TOTAL_SAMPLES   = 1050;
    localparam int TAIL_SAMPLES    = 150;
    localparam int RANDOM_END      = TOTAL_SAMPLES - TAIL_SAMPLES;
    localparam int SETTLE_CYCLES   = STAGES + 8;
    localparam int STALL_LIMIT     = 1000;
    localparam int MIX_MAX         = (1 << (MIC_W - 1)) - 1;
    localparam int MIX_MIN         = -(1 << (MIC_W - 1));

    // edge samples: with a quarter-turn step they meet the sine peaks
    localparam logic signed [MIC_W-1:0] EDGE_SAMPLES [12] = '{
        16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000,
        16'sd32700, 16'sd32700, -16'sd32700, -16'sd32700,
        16'sd0, 16'sd1, -16'sd1, 16'sh5555
    };

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   results_pending;
    int   samples_sent = 0;
    int   quiet_cycles = 0;
    bit   bursts_on    = 1'b0;

    slmt_in_if  mic_ch ();
    slmt_out_if mix_ch ();
    slmt_cfg_if cfg_ch ();

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    swept_level_tone_mixer_unit #(
        .SAMPLE_RATE     (SAMPLE_RATE),
        .SWEEP_SECONDS   (SWEEP_SECONDS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_mic   (mic_ch.sink),
        .o_mix   (mix_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    slmt_mix_checker #(
        .SAMPLE_RATE     (SAMPLE_RATE),
        .SWEEP_SECONDS   (SWEEP_SECONDS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) mix_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_mic        (mic_ch),
        .i_mix        (mix_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    // one sample beat; valid stays high for a following beat
    task automatic put_sample(input logic signed [MIC_W-1:0] v);
        mic_ch.valid      <= 1'b1;
        mic_ch.mic_sample <= v;
        do @(posedge clk); while (!mic_ch.ready);
        samples_sent++;
    endtask

    // one register write beat; the caller lowers valid after the last one
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // random idle burst on the sample side
    task automatic sender_gap();
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            mic_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // hold off samples until every result has come out
    task automatic drain();
        mic_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (STAGES + 2) @(posedge clk);
    endtask

    function automatic logic signed [MIC_W-1:0] random_mic();
        case ($urandom_range(0, 9))
            0:       return MIC_W'(MIX_MAX);
            1:       return MIC_W'(MIX_MIN);
            2:       return MIC_W'(int'($urandom_range(0, 600)) - 300);
            3:       return MIC_W'(MIX_MAX - int'($urandom_range(0, 300)));
            4:       return MIC_W'(MIX_MIN + int'($urandom_range(0, 300)));
            default: return MIC_W'($urandom());
        endcase
    endfunction

    // new register setting; high data bits are random noise
    task automatic random_setup();
        logic [CFG_DATA_W-1:0] st;
        logic [CFG_DATA_W-1:0] en;
        case ($urandom_range(0, 9))
            0:       st = '0;
            1:       st = '1;
            2:       st = {1'b1, 31'($urandom_range(1, 4096))};
            3:       st = $urandom_range(1, 1 << 20);
            default: st = $urandom();
        endcase
        en = ($urandom() & ~32'd1) | 32'($urandom_range(0, 3) != 0);
        set_reg(slmt_pkg::CFG_PHASE_STEP, st);
        set_reg(slmt_pkg::CFG_TONE_ENABLE, en);
        if ($urandom_range(0, 3) == 0) begin
            set_reg(CFG_IDX_W'($urandom_range(slmt_pkg::CFG_PHASE_STEP + 1,
                                              (1 << CFG_IDX_W) - 1)),
                    $urandom());
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: random stall bursts while enabled
    initial begin : result_sink
        mix_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (bursts_on && $urandom_range(0, 9) == 0) begin
                mix_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            mix_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk) begin
        if ((mic_ch.valid && mic_ch.ready) || (mix_ch.valid && mix_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int burst_len;
        mic_ch.valid      <= 1'b0;
        mic_ch.mic_sample <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        rst_n             <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // quarter-turn step, masked from a value with bit 31 set, and
        // writes to indexes past the register list
        set_reg(slmt_pkg::CFG_TONE_ENABLE, '1);
        set_reg(slmt_pkg::CFG_PHASE_STEP, 32'hC000_0000);
        set_reg(CFG_IDX_W'(slmt_pkg::CFG_PHASE_STEP + 1), '1);
        set_reg('1, '1);
        cfg_ch.valid <= 1'b0;
        bursts_on = 1'b1;
        foreach (EDGE_SAMPLES[i]) begin
            put_sample(EDGE_SAMPLES[i]);
            sender_gap();
        end

        // tone off, zero step: samples pass straight through
        drain();
        set_reg(slmt_pkg::CFG_PHASE_STEP, '0);
        set_reg(slmt_pkg::CFG_TONE_ENABLE, 32'hFFFF_FFFE);
        cfg_ch.valid <= 1'b0;
        put_sample(MIC_W'(MIX_MAX));
        put_sample(MIC_W'(MIX_MIN));
        put_sample(16'sh1234);

        // largest step
        drain();
        set_reg(slmt_pkg::CFG_TONE_ENABLE, 32'd1);
        set_reg(slmt_pkg::CFG_PHASE_STEP, 32'h7FFF_FFFF);
        cfg_ch.valid <= 1'b0;
        for (int i = 0; i < 6; i++) begin
            put_sample(EDGE_SAMPLES[i]);
        end

        // random settings and samples, each batch after a full drain
        while (samples_sent < RANDOM_END) begin
            drain();
            random_setup();
            bursts_on = ($urandom_range(0, 3) != 0);
            burst_len = $urandom_range(40, 150);
            if (burst_len > RANDOM_END - samples_sent) begin
                burst_len = RANDOM_END - samples_sent;
            end
            repeat (burst_len) begin
                put_sample(random_mic());
                sender_gap();
            end
        end

        // steady stream at the end, no idling on either side
        bursts_on = 1'b0;
        drain();
        set_reg(slmt_pkg::CFG_TONE_ENABLE, 32'd1);
        set_reg(slmt_pkg::CFG_PHASE_STEP, $urandom());
        cfg_ch.valid <= 1'b0;
        while (samples_sent < TOTAL_SAMPLES) begin
            put_sample(random_mic());
        end
        mic_ch.valid <= 1'b0;

        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
